FILE: rtl/sbmq_pkg.sv
`timescale 1ns / 1ps

package sbmq_pkg;

  localparam int DATA_W = 32;
  localparam int QID_W  = 2;
  localparam int ST_W   = 2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: rtl/shared_buffer_multi_queue.sv
`timescale 1ns / 1ps

// Several FIFO queues sharing one slot store. Each beat is a push (value onto
// queue) or a pop (oldest value of queue); each returns one result: ok, full or
// empty, with the popped word on an ok pop and zero otherwise. The block takes
// one beat per cycle with no bubbles while results are taken, and out_valid for
// a result rises after its beat passes the decision register and then the
// output register; a held result stalls the input once both are occupied. Each
// operation makes at most one read of the link store, whose registered read
// data is folded into the free-list and queue-head successor registers on the
// following cycle; that single link read port is what lets the next beat
// follow at once. Slots are handed out from the recycled list first and from a
// fresh-slot counter when that list is empty, so no clearing pass is needed
// after reset.
module shared_buffer_multi_queue #(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [sbmq_pkg::QID_W-1:0]        in_queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sbmq_pkg::ST_W-1:0]         out_status,
  output logic signed [sbmq_pkg::DATA_W-1:0] out_pop_data
);

  import sbmq_pkg::*;

  localparam int PW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  // queue state
  logic [PW-1:0] head_r [QUEUES];
  logic [PW-1:0] head_nxt [QUEUES];
  logic [PW-1:0] tail_r [QUEUES];
  logic [PW-1:0] tail_nxt [QUEUES];
  logic [PW-1:0] hn_r [QUEUES];
  logic [PW-1:0] hn_nxt [QUEUES];
  logic [PW-1:0] hn_eff [QUEUES];
  logic [QUEUES-1:0] qv_r, qv_nxt;

  // free space: fresh slots from bump upward, recycled slots on a linked list
  logic [CW-1:0] bump_r, bump_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic [PW-1:0] fh_r, fh_nxt;
  logic [PW-1:0] fhn_r, fhn_nxt, fhn_eff;

  // pending link read targets
  logic           pend_f_r, pend_f_nxt;
  logic           pend_q_r, pend_q_nxt;
  logic [QIW-1:0] pq_r, pq_nxt;

  // store ports
  logic          link_we, link_re;
  logic [PW-1:0] link_waddr, link_wdata, link_raddr, link_rd;
  logic          data_we, data_re;
  logic [PW-1:0] data_waddr, data_raddr;
  logic [DATA_W-1:0] data_rd;

  // pipeline
  logic            s1_v_r, s1_pop_r;
  logic [ST_W-1:0] s1_status_r;
  logic            o_v_r;
  logic [ST_W-1:0] o_status_r;
  logic signed [DATA_W-1:0] o_data_r;

  logic            in_fire, s1_adv;
  logic            q_ok, push_ok, pop_ok;
  logic [QIW-1:0]  qi;
  logic [PW-1:0]   slot_s;
  logic [ST_W-1:0] status_c;

  assign s1_adv   = s1_v_r && (!o_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign qi      = QIW'(in_queue_id);
  assign q_ok    = (32'(in_queue_id) < QUEUES);
  assign push_ok = (in_kind == KIND_PUSH) && q_ok && ((rc_r != '0) || (bump_r != CW'(SLOTS)));
  assign pop_ok  = (in_kind == KIND_POP) && q_ok && qv_r[qi];

  // fold last cycle's link read into the successor registers
  assign fhn_eff = pend_f_r ? link_rd : fhn_r;

  always_comb begin
    for (int i = 0; i < QUEUES; i++) begin
      hn_eff[i] = (pend_q_r && (pq_r == QIW'(i))) ? link_rd : hn_r[i];
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    hn_nxt     = hn_eff;
    qv_nxt     = qv_r;
    bump_nxt   = bump_r;
    rc_nxt     = rc_r;
    fh_nxt     = fh_r;
    fhn_nxt    = fhn_eff;
    pend_f_nxt = 1'b0;
    pend_q_nxt = 1'b0;
    pq_nxt     = pq_r;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_re    = 1'b0;
    link_raddr = '0;
    data_we    = 1'b0;
    data_waddr = '0;
    data_re    = 1'b0;
    data_raddr = '0;
    slot_s     = '0;
    status_c   = (in_kind == KIND_PUSH) ? ST_FULL : ST_EMPTY;
    if (in_fire && push_ok) begin
      status_c = ST_OK;
      if (rc_r != '0) begin
        slot_s     = fh_r;
        fh_nxt     = fhn_eff;
        rc_nxt     = rc_r - CW'(1);
        link_re    = 1'b1;
        link_raddr = fhn_eff;
        pend_f_nxt = 1'b1;
      end else begin
        slot_s   = bump_r[PW-1:0];
        bump_nxt = bump_r + CW'(1);
      end
      if (qv_r[qi]) begin
        link_we    = 1'b1;
        link_waddr = tail_r[qi];
        link_wdata = slot_s;
        if (head_r[qi] == tail_r[qi]) begin
          hn_nxt[qi] = slot_s;
        end
      end else begin
        head_nxt[qi] = slot_s;
        qv_nxt[qi]   = 1'b1;
      end
      tail_nxt[qi] = slot_s;
      data_we      = 1'b1;
      data_waddr   = slot_s;
    end else if (in_fire && pop_ok) begin
      status_c   = ST_OK;
      slot_s     = head_r[qi];
      data_re    = 1'b1;
      data_raddr = slot_s;
      // recycled slot goes to the front of the free list
      link_we    = 1'b1;
      link_waddr = slot_s;
      link_wdata = fh_r;
      fh_nxt     = slot_s;
      fhn_nxt    = fh_r;
      rc_nxt     = rc_r + CW'(1);
      if (head_r[qi] == tail_r[qi]) begin
        qv_nxt[qi] = 1'b0;
      end else begin
        head_nxt[qi] = hn_eff[qi];
        link_re      = 1'b1;
        link_raddr   = hn_eff[qi];
        pend_q_nxt   = 1'b1;
        pq_nxt       = qi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r     <= '0;
      bump_r   <= '0;
      rc_r     <= '0;
      pend_f_r <= 1'b0;
      pend_q_r <= 1'b0;
    end else begin
      qv_r     <= qv_nxt;
      bump_r   <= bump_nxt;
      rc_r     <= rc_nxt;
      pend_f_r <= pend_f_nxt;
      pend_q_r <= pend_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    hn_r   <= hn_nxt;
    fh_r   <= fh_nxt;
    fhn_r  <= fhn_nxt;
    pq_r   <= pq_nxt;
  end

  sbmq_ram #(
    .W     (PW),
    .DEPTH (SLOTS)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  sbmq_ram #(
    .W     (DATA_W),
    .DEPTH (SLOTS)
  ) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (in_value),
    .re    (data_re),
    .raddr (data_raddr),
    .rdata (data_rd)
  );

  // result pipeline: decision stage, then output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_fire;
      end
      if (!o_v_r || out_ready) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= status_c;
      s1_pop_r    <= pop_ok;
    end
    if (s1_adv) begin
      o_status_r <= s1_status_r;
      o_data_r   <= s1_pop_r ? data_rd : '0;
    end
  end

  assign out_valid    = o_v_r;
  assign out_status   = o_status_r;
  assign out_pop_data = o_data_r;

  a_recycled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= bump_r)
    else $error("recycled count exceeds allocated slots");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_f_r && pend_q_r))
    else $error("two link reads in flight");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !push_ok && !pop_ok |=> $stable(rc_r) && $stable(bump_r) && $stable(qv_r))
    else $error("refused beat changed queue state");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_pop_data == '0))
    else $error("refused result carries data");

endmodule

FILE: rtl/sbmq_ram.sv
`timescale 1ns / 1ps

module sbmq_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
